// File: rtl/brrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brrs_pkg: shared types for the Boolean row reduce/scan block
// Payload structs, operation codes and register indexes.
// ----------------------------------------------------------------------------
package brrs_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 3;
  localparam longint unsigned MaxRowLengthDefault = 64'd65535;

  typedef enum logic [2:0] {
    OP_CARET_REDUCE = 3'd0,
    OP_CARET_SCAN   = 3'd1,
    OP_EQ_REDUCE    = 3'd2,
    OP_NE_REDUCE    = 3'd3,
    OP_EQ_SCAN      = 3'd4,
    OP_NE_SCAN      = 3'd5,
    OP_PLUS_REDUCE  = 3'd6
  } op_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_OPERATION         = 2'd0,
    REG_MARKER_COMPLEMENT = 2'd1,
    REG_IDENTITY_BIT      = 2'd2,
    REG_SUFFIX_BIT        = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic data_bit;
    logic last_in_row;
  } in_item_t;

  typedef struct packed {
    logic                  result_bit;
    logic [CountWidth-1:0] ones_count;
    logic                  row_done;
  } out_item_t;

endpackage

// File: rtl/boolean_row_reduce_scan_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boolean_row_reduce_scan_top: Boolean reduce and scan along rows
// Caret reduce/scan by the first-marker method, equal and not-equal by
// parity, and a saturating ones count for plus reduce.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                         Direction  Transfer when
//   in        in_valid, in_stall, in_data     sink       in_valid && !in_stall
//   out       out_valid, out_stall, out_data  source     out_valid && !out_stall
//   cfg       cfg_we, cfg_index, cfg_data     sink       cfg_we
//
// One element per cycle unless stalled: each passes through one level of logic
// into the output register, so a result appears the cycle after its transfer.
// The output register frees itself in the cycle it is taken, so input stalls
// only while a result is held by out_stall.
// Reset (rst, synchronous) clears the configuration registers, the row state and out_valid.
// Reductions give a result only on the element that closes its row.
// ----------------------------------------------------------------------------
module boolean_row_reduce_scan_top #(
  parameter longint unsigned MAX_ROW_LENGTH = brrs_pkg::MaxRowLengthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  brrs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output brrs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [brrs_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [brrs_pkg::CfgDataWidth-1:0]   cfg_data
);

  localparam logic [brrs_pkg::CountWidth-1:0] CountCeiling =
    (MAX_ROW_LENGTH < 64'd65535) ? MAX_ROW_LENGTH[brrs_pkg::CountWidth-1:0]
                                 : {brrs_pkg::CountWidth{1'b1}};

  // configuration
  brrs_pkg::op_t operation;
  logic          marker_complement;
  logic          identity_bit;
  logic          suffix_bit;

  // row state; only the parity of the position ever reaches a result
  logic                            pos_parity;
  logic                            marker_seen;
  logic                            infix_value;
  logic [brrs_pkg::CountWidth-1:0] ones_so_far;
  logic                            zeros_parity;

  logic                            pos_parity_next;
  logic                            marker_seen_next;
  logic                            infix_value_next;
  logic [brrs_pkg::CountWidth-1:0] ones_so_far_next;
  logic                            zeros_parity_next;

  logic                accept;
  logic                is_marker;
  logic                prefix_bit;
  logic                caret_bit;
  logic                ones_parity;
  logic                emit;
  brrs_pkg::out_item_t result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_marker  = (in_data.data_bit == !marker_complement);
    prefix_bit = pos_parity ? identity_bit : marker_complement;

    marker_seen_next = marker_seen;
    infix_value_next = infix_value;
    if (marker_seen) begin
      caret_bit = (infix_value == suffix_bit);
    end else if (is_marker) begin
      marker_seen_next = 1'b1;
      infix_value_next = !prefix_bit;
      caret_bit        = !prefix_bit;
    end else begin
      caret_bit = prefix_bit;
    end

    zeros_parity_next = zeros_parity ^ !in_data.data_bit;
    if (in_data.data_bit && (ones_so_far < CountCeiling)) begin
      ones_so_far_next = ones_so_far + brrs_pkg::CountWidth'(1);
    end else begin
      ones_so_far_next = ones_so_far;
    end
    pos_parity_next = !pos_parity;
    ones_parity     = pos_parity_next ^ zeros_parity_next;

    emit              = 1'b0;
    result.result_bit = 1'b0;
    result.ones_count = '0;
    result.row_done   = in_data.last_in_row;
    case (operation)
      brrs_pkg::OP_CARET_REDUCE: begin
        emit              = in_data.last_in_row;
        result.result_bit = caret_bit;
      end
      brrs_pkg::OP_CARET_SCAN: begin
        emit              = 1'b1;
        result.result_bit = caret_bit;
      end
      brrs_pkg::OP_EQ_REDUCE: begin
        emit              = in_data.last_in_row;
        result.result_bit = !zeros_parity_next;
      end
      brrs_pkg::OP_NE_REDUCE: begin
        emit              = in_data.last_in_row;
        result.result_bit = ones_parity;
      end
      brrs_pkg::OP_EQ_SCAN: begin
        emit              = 1'b1;
        result.result_bit = !zeros_parity_next;
      end
      brrs_pkg::OP_NE_SCAN: begin
        emit              = 1'b1;
        result.result_bit = ones_parity;
      end
      brrs_pkg::OP_PLUS_REDUCE: begin
        emit              = in_data.last_in_row;
        result.ones_count = ones_so_far_next;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      operation         <= brrs_pkg::OP_CARET_REDUCE;
      marker_complement <= 1'b0;
      identity_bit      <= 1'b0;
      suffix_bit        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        brrs_pkg::REG_OPERATION:         operation <= brrs_pkg::op_t'(cfg_data);
        brrs_pkg::REG_MARKER_COMPLEMENT: marker_complement <= cfg_data[0];
        brrs_pkg::REG_IDENTITY_BIT:      identity_bit <= cfg_data[0];
        brrs_pkg::REG_SUFFIX_BIT:        suffix_bit <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // row state: advance on each transfer, clear at the row end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_parity   <= 1'b0;
      marker_seen  <= 1'b0;
      infix_value  <= 1'b0;
      ones_so_far  <= '0;
      zeros_parity <= 1'b0;
    end else if (accept) begin
      if (in_data.last_in_row) begin
        pos_parity   <= 1'b0;
        marker_seen  <= 1'b0;
        infix_value  <= 1'b0;
        ones_so_far  <= '0;
        zeros_parity <= 1'b0;
      end else begin
        pos_parity   <= pos_parity_next;
        marker_seen  <= marker_seen_next;
        infix_value  <= infix_value_next;
        ones_so_far  <= ones_so_far_next;
        zeros_parity <= zeros_parity_next;
      end
    end
  end

  // output register: load on transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= result;
    end
  end

  // assertions
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.last_in_row |=>
      !pos_parity && !marker_seen && !zeros_parity && (ones_so_far == '0))
    else $error("row state not cleared after the row end");

  a_count_ceiling: assert property (@(posedge clk) disable iff (rst)
    ones_so_far <= CountCeiling)
    else $error("ones count above its ceiling");

  a_count_only_at_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.ones_count != '0) |->
      out_data.row_done && !out_data.result_bit)
    else $error("ones count shown outside a plus reduce row result");

endmodule
